// ===== rtl/tpp_pkg.sv =====
// Shared types, widths and helpers for the triaxial Plummer potential core.
// No dependencies; every other file but tpp_isqrt imports this package.
package tpp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int OUT_W         = 32;
	localparam int MASS_W        = 32;
	localparam int CORE_W        = 32;
	localparam int WT_W          = 24;
	localparam int CFG_W         = 32;
	localparam int QUO_W         = 32;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_MASS     = 2'd0,
		REG_CORE     = 2'd1,
		REG_Y_WEIGHT = 2'd2,
		REG_Z_WEIGHT = 2'd3
	} cfg_reg_t;

	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	// quotient of one pipelined divider, ovf set when it needs more than QUO_W bits
	typedef struct packed {
		logic [QUO_W-1:0] q;
		logic             ovf;
	} div_res_t;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             sat;
	} sat_out_t;

	// apply sign to a magnitude and clip to the signed output range
	function automatic sat_out_t clip_out(input div_res_t d, input logic neg);
		sat_out_t         r;
		logic [OUT_W-1:0] lim;
		logic [OUT_W-1:0] m;
		lim     = neg ? OUT_MIN : OUT_MAX;
		r.sat   = d.ovf || (d.q > lim);
		m       = r.sat ? lim : d.q;
		r.value = neg ? (~m + 1'b1) : m;
		return r;
	endfunction

endpackage

// ===== rtl/tpp_if.sv =====
// Valid/ready channel interfaces: position beats in, result beats out.
// Depends on tpp_pkg for field widths.
interface tpp_pos_if import tpp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	modport source (output valid, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface tpp_res_if import tpp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] potential;
	logic signed [OUT_W-1:0] acc_x;
	logic signed [OUT_W-1:0] acc_y;
	logic signed [OUT_W-1:0] acc_z;
	logic                    saturated;
	modport source (output valid, potential, acc_x, acc_y, acc_z, saturated, input ready);
	modport sink (input valid, potential, acc_x, acc_y, acc_z, saturated, output ready);
endinterface

// ===== rtl/tpp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side
// payload that travels alongside. No package dependencies.
module tpp_isqrt #(
	parameter int V_W    = 74,
	parameter int SIDE_W = 8
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [V_W-1:0]         v,
	input  logic [SIDE_W-1:0]      side,
	output logic [(V_W+1)/2-1:0]   root,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int R_W = (V_W + 1) / 2;
	localparam int T_W = 2 * R_W + 1;

	logic [V_W-1:0]    rem_s  [0:R_W-2];
	logic [R_W-1:0]    res_s  [0:R_W-1];
	logic [SIDE_W-1:0] side_s [0:R_W-1];

	for (genvar k = 0; k < R_W; k++) begin : g_stage
		localparam int B = R_W - 1 - k;
		logic [V_W-1:0]    rem_in;
		logic [R_W-1:0]    res_in;
		logic [SIDE_W-1:0] side_in;
		logic [T_W-1:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_in  = v;
			assign res_in  = '0;
			assign side_in = side;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign res_in  = res_s[k-1];
			assign side_in = side_s[k-1];
		end

		// (res + 2^B)^2 - res^2, res holding only bits above B
		assign trial = (T_W'(res_in) << (B + 1)) | (T_W'(1) << (2 * B));
		assign ge    = T_W'(rem_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				res_s[k]  <= ge ? (res_in | (R_W'(1) << B)) : res_in;
				side_s[k] <= side_in;
			end
		end

		if (k < R_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? V_W'(T_W'(rem_in) - trial) : rem_in;
				end
			end
		end
	end

	assign root     = res_s[R_W-1];
	assign side_out = side_s[R_W-1];

endmodule

// ===== rtl/tpp_div.sv =====
// Pipelined restoring divider: overflow check stage, then one quotient bit
// per stage. Depends on tpp_pkg (div_res_t, QUO_W).
module tpp_div import tpp_pkg::*; #(
	parameter int N_W = 104,
	parameter int D_W = 111
) (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] n,
	input  logic [D_W-1:0] d,
	output div_res_t       res_o
);

	localparam int W = (N_W > D_W + QUO_W) ? N_W : D_W + QUO_W;

	logic [W-1:0]     r_s   [0:QUO_W-1];
	logic [D_W-1:0]   d_s   [0:QUO_W-1];
	logic [QUO_W-1:0] q_s   [0:QUO_W];
	logic             ovf_s [0:QUO_W];

	// first stage: flag quotients that do not fit in QUO_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= W'(n);
			d_s[0]   <= d;
			q_s[0]   <= '0;
			ovf_s[0] <= W'(n) >= (W'(d) << QUO_W);
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		localparam int I = QUO_W - k;
		logic [W-1:0] dsh;
		logic         ge;

		assign dsh = W'(d_s[k-1]) << I;
		assign ge  = r_s[k-1] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k]   <= {q_s[k-1][QUO_W-2:0], ge};
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		if (k < QUO_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k] <= ge ? (r_s[k-1] - dsh) : r_s[k-1];
					d_s[k] <= d_s[k-1];
				end
			end
		end
	end

	assign res_o.q   = q_s[QUO_W];
	assign res_o.ovf = ovf_s[QUO_W];

endmodule

// ===== rtl/triaxial_plummer_potential_core.sv =====
// Top level of the flattened Plummer potential and acceleration evaluator.
// Depends on tpp_pkg, tpp_if (channels), tpp_isqrt and tpp_div.
//
//   channel  dir  handshake    payload
//   pos      in   valid/ready  pos_x, pos_y, pos_z
//   res      out  valid/ready  potential, acc_x, acc_y, acc_z, saturated
//   cfg      in   cfg_we       cfg_idx, cfg_data
//
// One position per cycle while no result beat is held at the output. Stages in
// order: five front stages, the square root at one bit per stage, three
// product stages, the dividers (an overflow check stage, then one quotient bit
// per stage), then the output register.
// A single enable moves every stage; it drops only while a result beat is
// held at the output, so a stall freezes the whole pipe.
// Reset clears the valid bits and loads the configuration defaults.
module triaxial_plummer_potential_core import tpp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_reg_t         cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	tpp_pos_if.sink          pos,
	tpp_res_if.source        res
);

	localparam int SQ_W    = 2 * COORD_W;
	localparam int HALF_W  = COORD_W;
	localparam int MM_W    = MASS_W + COORD_W;
	localparam int HP_W    = HALF_W + WT_W;
	localparam int FULL_W  = SQ_W + WT_W;
	localparam int TERM_W  = FULL_W - FRAC_BITS;
	localparam int D2_W    = TERM_W + 2;
	localparam int ROOT_W  = (D2_W + 1) / 2;
	localparam int NUM_W   = MM_W + WT_W + FRAC_BITS;
	localparam int POT_W   = MASS_W + FRAC_BITS;
	localparam int PROD_W  = D2_W + ROOT_W;
	localparam int CH_W    = 24;
	localparam int NCH     = (D2_W + CH_W - 1) / CH_W;
	localparam int DP_W    = NCH * CH_W;
	localparam int RH_W    = (ROOT_W + 1) / 2;
	localparam int RP_W    = 2 * RH_W;
	localparam int PP_W    = CH_W + RH_W;
	localparam int SIDE_W  = D2_W + 3 * NUM_W + 3;
	localparam int DIV_LAT = QUO_W + 1;
	localparam int LAT     = 5 + ROOT_W + 3 + DIV_LAT + 1;
	localparam int V_S8    = 5 + ROOT_W + 3 - 1;

	// configuration registers
	logic [MASS_W-1:0] mass_q;
	logic [CORE_W-1:0] core_q;
	logic [WT_W-1:0]   yw_q;
	logic [WT_W-1:0]   zw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_W'(1) << FRAC_BITS;
			core_q <= CORE_W'(1) << FRAC_BITS;
			yw_q   <= WT_W'(1) << FRAC_BITS;
			zw_q   <= WT_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MASS:     mass_q <= cfg_data;
				REG_CORE:     core_q <= cfg_data;
				REG_Y_WEIGHT: yw_q   <= cfg_data[WT_W-1:0];
				REG_Z_WEIGHT: zw_q   <= cfg_data[WT_W-1:0];
				default:      ;
			endcase
		end
	end

	// pipe control
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || res.ready;
	assign pos.ready = en;
	assign res.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pos.valid};
		end
	end

	// s1: magnitudes and signs
	logic [COORD_W-1:0] coord  [3];
	logic [COORD_W-1:0] mag_s1 [3];
	logic [2:0]         neg_s1;

	assign coord[0] = pos.pos_x;
	assign coord[1] = pos.pos_y;
	assign coord[2] = pos.pos_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= coord[i][COORD_W-1];
				mag_s1[i] <= coord[i][COORD_W-1] ? (~coord[i] + 1'b1) : coord[i];
			end
		end
	end

	// s2: squares and mass * |c|
	logic [SQ_W-1:0] sq_s2 [3];
	logic [MM_W-1:0] mm_s2 [3];
	logic [2:0]      neg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= mag_s1[i] * mag_s1[i];
				mm_s2[i] <= mass_q * mag_s1[i];
			end
			neg_s2 <= neg_s1;
		end
	end

	// s3: weight products, split in halves
	logic [WT_W-1:0] wt [1:2];
	logic [HP_W-1:0] sq_lo_s3 [1:2];
	logic [HP_W-1:0] sq_hi_s3 [1:2];
	logic [HP_W-1:0] mm_lo_s3 [1:2];
	logic [HP_W-1:0] mm_hi_s3 [1:2];
	logic [SQ_W-1:0] sqx_s3;
	logic [MM_W-1:0] mmx_s3;
	logic [2:0]      neg_s3;

	assign wt[1] = yw_q;
	assign wt[2] = zw_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 1; a <= 2; a++) begin
				sq_lo_s3[a] <= sq_s2[a][HALF_W-1:0] * wt[a];
				sq_hi_s3[a] <= sq_s2[a][SQ_W-1:HALF_W] * wt[a];
				mm_lo_s3[a] <= mm_s2[a][HALF_W-1:0] * wt[a];
				mm_hi_s3[a] <= mm_s2[a][MM_W-1:HALF_W] * wt[a];
			end
			sqx_s3 <= sq_s2[0];
			mmx_s3 <= mm_s2[0];
			neg_s3 <= neg_s2;
		end
	end

	// s4: weighted terms and acceleration numerators
	logic [FULL_W-1:0] sq_full [1:2];
	logic [FULL_W-1:0] mm_full [1:2];
	logic [TERM_W-1:0] term_s4 [1:2];
	logic [NUM_W-1:0]  num_s4  [3];
	logic [SQ_W-1:0]   sqx_s4;
	logic [2:0]        neg_s4;

	always_comb begin
		for (int a = 1; a <= 2; a++) begin
			sq_full[a] = (FULL_W'(sq_hi_s3[a]) << HALF_W) + FULL_W'(sq_lo_s3[a]);
			mm_full[a] = (FULL_W'(mm_hi_s3[a]) << HALF_W) + FULL_W'(mm_lo_s3[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 1; a <= 2; a++) begin
				term_s4[a] <= TERM_W'(sq_full[a] >> FRAC_BITS);
				num_s4[a]  <= NUM_W'(mm_full[a]) << FRAC_BITS;
			end
			num_s4[0] <= NUM_W'(mmx_s3) << (2 * FRAC_BITS);
			sqx_s4    <= sqx_s3;
			neg_s4    <= neg_s3;
		end
	end

	// s5: radius term plus core, zero forced to one
	logic [D2_W-1:0]  d2_sum;
	logic [D2_W-1:0]  d2_s5;
	logic [NUM_W-1:0] num_s5 [3];
	logic [2:0]       neg_s5;

	assign d2_sum = D2_W'(sqx_s4) + D2_W'(term_s4[1]) + D2_W'(term_s4[2])
		+ (D2_W'(core_q) << FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s5  <= (d2_sum == '0) ? D2_W'(1) : d2_sum;
			num_s5 <= num_s4;
			neg_s5 <= neg_s4;
		end
	end

	// square root, carrying d2, numerators and signs
	logic [ROOT_W-1:0] root_sq;
	logic [SIDE_W-1:0] side_sq;
	logic [D2_W-1:0]   d2_sq;
	logic [NUM_W-1:0]  num_sq [3];
	logic [2:0]        neg_sq;

	tpp_isqrt #(
		.V_W    (D2_W),
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.en       (en),
		.v        (d2_s5),
		.side     ({d2_s5, num_s5[0], num_s5[1], num_s5[2], neg_s5}),
		.root     (root_sq),
		.side_out (side_sq)
	);

	assign {d2_sq, num_sq[0], num_sq[1], num_sq[2], neg_sq} = side_sq;

	// s6: partial products of d2 * root
	logic [ROOT_W-1:0] root_fix;
	logic [DP_W-1:0]   d2_pad;
	logic [RP_W-1:0]   root_pad;
	logic [PP_W-1:0]   pp_s6 [2][NCH];
	logic [ROOT_W-1:0] root_s6;
	logic [NUM_W-1:0]  num_s6 [3];
	logic [2:0]        neg_s6;

	assign root_fix = (root_sq == '0) ? ROOT_W'(1) : root_sq;
	assign d2_pad   = DP_W'(d2_sq);
	assign root_pad = RP_W'(root_fix);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int h = 0; h < 2; h++) begin
				for (int j = 0; j < NCH; j++) begin
					pp_s6[h][j] <= d2_pad[j*CH_W +: CH_W] * root_pad[h*RH_W +: RH_W];
				end
			end
			root_s6 <= root_fix;
			num_s6  <= num_sq;
			neg_s6  <= neg_sq;
		end
	end

	// s7: sum per root half
	logic [PROD_W-1:0] psum     [2];
	logic [PROD_W-1:0] psum_s7  [2];
	logic [ROOT_W-1:0] root_s7;
	logic [NUM_W-1:0]  num_s7   [3];
	logic [2:0]        neg_s7;

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			psum[h] = '0;
			for (int j = 0; j < NCH; j++) begin
				psum[h] = psum[h] + (PROD_W'(pp_s6[h][j]) << (CH_W * j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psum_s7 <= psum;
			root_s7 <= root_s6;
			num_s7  <= num_s6;
			neg_s7  <= neg_s6;
		end
	end

	// s8: full divisor for the accelerations
	logic [PROD_W-1:0] prod_s8;
	logic [ROOT_W-1:0] root_s8;
	logic [NUM_W-1:0]  num_s8 [3];
	logic [2:0]        neg_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s8 <= psum_s7[0] + (psum_s7[1] << RH_W);
			root_s8 <= root_s7;
			num_s8  <= num_s7;
			neg_s8  <= neg_s7;
		end
	end

	// dividers: potential by root, accelerations by d2 * root
	div_res_t pot_div;
	div_res_t acc_div [3];

	tpp_div #(
		.N_W (POT_W),
		.D_W (ROOT_W)
	) u_div_pot (
		.clk   (clk),
		.en    (en),
		.n     (POT_W'(mass_q) << FRAC_BITS),
		.d     (root_s8),
		.res_o (pot_div)
	);

	for (genvar i = 0; i < 3; i++) begin : g_acc
		tpp_div #(
			.N_W (NUM_W),
			.D_W (PROD_W)
		) u_div_acc (
			.clk   (clk),
			.en    (en),
			.n     (num_s8[i]),
			.d     (prod_s8),
			.res_o (acc_div[i])
		);
	end

	// signs ride along with the dividers
	logic [2:0] neg_dl_s [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_dl_s[0] <= neg_s8;
			for (int k = 1; k < DIV_LAT; k++) begin
				neg_dl_s[k] <= neg_dl_s[k-1];
			end
		end
	end

	// output register: sign, clip, saturation flag
	sat_out_t         pot_c;
	sat_out_t         acc_c [3];
	logic [OUT_W-1:0] pot_q;
	logic [OUT_W-1:0] acc_q [3];
	logic             sat_q;

	always_comb begin
		pot_c = clip_out(pot_div, 1'b1);
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = clip_out(acc_div[i], !neg_dl_s[DIV_LAT-1][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pot_q <= pot_c.value;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= acc_c[i].value;
			end
			sat_q <= pot_c.sat || acc_c[0].sat || acc_c[1].sat || acc_c[2].sat;
		end
	end

	assign res.potential = pot_q;
	assign res.acc_x     = acc_q[0];
	assign res.acc_y     = acc_q[1];
	assign res.acc_z     = acc_q[2];
	assign res.saturated = sat_q;

	// checks
	a_prod_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[V_S8] |-> prod_s8 != '0)
		else $error("acceleration divisor is zero");

	a_pot_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.potential[OUT_W-1] || res.potential == '0))
		else $error("potential is positive");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.saturated) |-> (res.potential == OUT_MIN
			|| res.acc_x == OUT_MIN || res.acc_x == OUT_MAX
			|| res.acc_y == OUT_MIN || res.acc_y == OUT_MAX
			|| res.acc_z == OUT_MIN || res.acc_z == OUT_MAX))
		else $error("saturated flag without a clipped value");

endmodule
